// File: src/cdm_pkg.sv
// Shared types, constants, exp tables and fp16 helper functions for the decay mask block.
package cdm_pkg;

    localparam int IDX_W  = 4;
    localparam int HALF_W = 16;
    localparam int QDEPTH = 4;

    localparam logic [15:0] H_QNAN = 16'h7E00;
    localparam logic [14:0] H_INF  = 15'h7C00;

    localparam real LOG2E = 1.4426950408889634;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_ELEM,
        KIND_ZERO
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [HALF_W-1:0] value;
    } t_qent;

    typedef logic [255:0][31:0] t_tab256;
    typedef logic [63:0][31:0]  t_tab64;
    typedef logic [63:0][7:0]   t_exp64;

    // exp(i * 2^-pos) for i = 0..255, scaled by 2^scale_bits and rounded.
    function automatic t_tab256 make_tab(input int pos, input int scale_bits);
        t_tab256 t;
        real     v;
        for (int i = 0; i < 256; i++) begin
            v    = $exp(real'(i) * $pow(2.0, -pos)) * $pow(2.0, scale_bits);
            t[i] = 32'(longint'(v));
        end
        return t;
    endfunction

    // Binary exponent of exp(n) for the signed integer n held in a 6-bit code.
    function automatic t_exp64 make_c3e();
        t_exp64 t;
        int     n;
        real    ex;
        for (int i = 0; i < 64; i++) begin
            n    = (i < 32) ? i : i - 64;
            ex   = $floor(real'(n) * LOG2E);
            t[i] = 8'(int'(ex));
        end
        return t;
    endfunction

    // Significand of exp(n) in 1.31 format, matching make_c3e.
    function automatic t_tab64 make_c3m();
        t_tab64 t;
        int     n;
        real    ex;
        real    m;
        longint q;
        for (int i = 0; i < 64; i++) begin
            n  = (i < 32) ? i : i - 64;
            ex = $floor(real'(n) * LOG2E);
            m  = $exp(real'(n)) * $pow(2.0, -ex);
            q  = longint'(m * $pow(2.0, 31));
            if (q > 64'sh0_FFFF_FFFF) begin
                q = 64'sh0_FFFF_FFFF;
            end
            t[i] = 32'(q);
        end
        return t;
    endfunction

    localparam t_tab256 T_C2  = make_tab(8, 30);
    localparam t_tab256 T_C1  = make_tab(16, 31);
    localparam t_tab256 T_C0  = make_tab(24, 31);
    localparam t_tab64  T_C3M = make_c3m();
    localparam t_exp64  T_C3E = make_c3e();

    function automatic logic is_nan(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic logic is_inf(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    endfunction

    // Magnitude of a finite fp16 value as fixed point with LSB 2^-24.
    function automatic logic [40:0] half_to_fix41(input logic [15:0] h);
        logic [40:0] mag;
        if (h[14:10] == 5'd0) begin
            mag = {31'd0, h[9:0]};
        end else begin
            mag = 41'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
        end
        return mag;
    endfunction

    function automatic logic [5:0] lead41(input logic [40:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 41; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [4:0] lead22(input logic [21:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 22; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // Round 1.sig * 2^e (sig[39] is the leading one) to nearest-even fp16,
    // with gradual underflow and overflow to infinity.
    function automatic logic [15:0] round_pack(input logic s, input logic signed [9:0] e,
                                               input logic [39:0] sig, input logic sticky);
        logic [3:0]  sh;
        logic [51:0] ext;
        logic [10:0] q;
        logic        g;
        logic        st;
        logic        rnd;
        logic [11:0] q12;
        logic [4:0]  base;
        logic [16:0] r;
        logic [15:0] res;
        if (e > 10'sd15) begin
            res = {s, H_INF};
        end else if (e < -10'sd25) begin
            res = {s, 15'd0};
        end else begin
            sh   = (e < -10'sd14) ? 4'(-10'sd14 - e) : 4'd0;
            ext  = {sig, 12'd0} >> sh;
            q    = ext[51:41];
            g    = ext[40];
            st   = (|ext[39:0]) | sticky;
            rnd  = g & (st | q[0]);
            q12  = {1'b0, q} + {11'd0, rnd};
            base = (sh == 4'd0) ? 5'(e + 10'sd14) : 5'd0;
            r    = {2'b00, base, 10'd0} + {5'd0, q12};
            res  = (r >= 17'h07C00) ? {s, H_INF} : {s, r[14:0]};
        end
        return res;
    endfunction

endpackage

// File: src/cdm_front.sv
// Input stage: accepts items, checks indexes and classifies each item for the queue.
module cdm_front #(
    parameter int SIDE = 16
) (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_cmd,
    input  logic [cdm_pkg::IDX_W-1:0] i_row_index,
    input  logic [cdm_pkg::IDX_W-1:0] i_col_index,
    input  logic [15:0]               i_half_value,
    input  logic                      i_full,
    output logic                      o_push,
    output cdm_pkg::t_qent            o_ent
);
    import cdm_pkg::*;

    logic row_ok;
    logic col_ok;
    logic accept;

    assign row_ok  = 32'(i_row_index) < SIDE;
    assign col_ok  = 32'(i_col_index) < SIDE;
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        o_ent.row   = i_row_index;
        o_ent.col   = i_col_index;
        o_ent.value = i_half_value;
        if (!i_cmd) begin
            // A load outside the tile is dropped here.
            o_ent.kind = KIND_LOAD;
            o_push     = accept && row_ok;
        end else begin
            if (row_ok && col_ok && (i_col_index <= i_row_index)) begin
                o_ent.kind = KIND_ELEM;
            end else begin
                o_ent.kind = KIND_ZERO;
            end
            o_push = accept;
        end
    end

endmodule

// File: src/cdm_queue.sv
// Short FIFO of classified items between the input stage and the datapath.
module cdm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cdm_pkg::t_qent i_ent,
    output logic           o_full,
    output logic           o_valid,
    output cdm_pkg::t_qent o_ent,
    input  logic           i_pop
);
    import cdm_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_qent         r_buf [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic [PW:0]   n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_buf[r_rp];

    always_comb begin
        n_cnt = r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_ent;
        end
    end

endmodule

// File: src/cdm_back.sv
// Datapath: gate memory, fp16 subtract, table-based exp, fp16 multiply, output register.
module cdm_back #(
    parameter int SIDE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ent_valid,
    input  cdm_pkg::t_qent i_ent,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_masked_value
);
    import cdm_pkg::*;

    localparam int AW = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int NS = 12;

    logic [15:0]   r_mem [SIDE];
    logic [NS-1:0] r_v;
    logic [NS-1:0] r_z;
    logic          en;
    logic          is_load;

    // Stage 1: gate reads
    logic [15:0] r_ga1, r_gb1, r_val1;
    // Stage 2: exact fixed-point difference
    logic signed [42:0] r_d2, n_d2;
    logic        r_sp2, n_sp2;
    logic [15:0] r_spv2, n_spv2, r_val2;
    // Stage 3: magnitude and leading one
    logic [40:0] r_mag3;
    logic [5:0]  r_p3;
    logic        r_s3, r_nz3, r_sp3;
    logic [15:0] r_spv3, r_val3;
    // Stage 4: rounded difference
    logic [15:0] r_diff4, n_diff4, r_val4;
    // Stage 5: fixed-point exp argument
    logic signed [29:0] r_x5, n_x5;
    logic        r_xs5, n_xs5;
    logic [15:0] r_xv5, n_xv5, r_val5;
    // Stages 6 to 8: table products
    logic [63:0] r_p6, r_p7, r_p8;
    logic [7:0]  r_c0_6;
    logic [5:0]  r_c3_6, r_c3_7;
    logic signed [7:0] r_e8;
    logic        r_xs6, r_xs7, r_xs8;
    logic [15:0] r_xv6, r_xv7, r_xv8, r_val6, r_val7, r_val8;
    logic [31:0] a7, b8;
    // Stage 9: rounded exp
    logic [15:0] r_ratio9, n_ratio9, r_val9;
    // Stage 10 to 12: multiply
    logic [21:0] r_prod10, n_prod10, r_prod11;
    logic signed [6:0] r_es10, n_es10, r_es11;
    logic        r_ms10, n_ms10, r_ms11;
    logic        r_msp10, n_msp10, r_msp11;
    logic [15:0] r_mspv10, n_mspv10, r_mspv11;
    logic [4:0]  r_lp11;
    logic [15:0] r_out, n_out;

    assign en             = !r_v[NS-1] || i_ready;
    assign o_pop          = i_ent_valid && en;
    assign is_load        = (i_ent.kind == KIND_LOAD);
    assign o_valid        = r_v[NS-1];
    assign o_masked_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_ent_valid && !is_load};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_load) begin
            r_mem[AW'(i_ent.row)] <= i_ent.value;
        end
    end

    // Stage 2 logic.
    always_comb begin
        logic [40:0] fa;
        logic [40:0] fb;
        logic signed [42:0] sa;
        logic signed [42:0] sb;
        fa = half_to_fix41(r_ga1);
        fb = half_to_fix41(r_gb1);
        sa = r_ga1[15] ? -$signed({2'b00, fa}) : $signed({2'b00, fa});
        sb = r_gb1[15] ? -$signed({2'b00, fb}) : $signed({2'b00, fb});
        n_d2 = sa - sb;
        n_sp2  = 1'b1;
        n_spv2 = H_QNAN;
        if (is_nan(r_ga1) || is_nan(r_gb1) ||
            (is_inf(r_ga1) && is_inf(r_gb1) && (r_ga1[15] == r_gb1[15]))) begin
            n_spv2 = H_QNAN;
        end else if (is_inf(r_ga1)) begin
            n_spv2 = {r_ga1[15], H_INF};
        end else if (is_inf(r_gb1)) begin
            n_spv2 = {~r_gb1[15], H_INF};
        end else begin
            n_sp2 = 1'b0;
        end
    end

    // Stage 4 logic: normalize and round the difference.
    always_comb begin
        logic [40:0] norm;
        logic signed [9:0] e;
        norm = r_mag3 << (6'd40 - r_p3);
        e    = $signed({4'd0, r_p3}) - 10'sd24;
        if (r_sp3) begin
            n_diff4 = r_spv3;
        end else if (!r_nz3) begin
            n_diff4 = 16'h0000;
        end else begin
            n_diff4 = round_pack(r_s3, e, norm[40:1], norm[0]);
        end
    end

    // Stage 5 logic: range checks and conversion of the exp argument.
    always_comb begin
        logic [4:0]  ex;
        logic [28:0] mag;
        ex    = r_diff4[14:10];
        mag   = (ex == 5'd0) ? {19'd0, r_diff4[9:0]}
                             : 29'({1'b1, r_diff4[9:0]}) << (ex - 5'd1);
        n_xs5 = 1'b1;
        n_xv5 = 16'h0000;
        n_x5  = r_diff4[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (is_nan(r_diff4)) begin
            n_xv5 = H_QNAN;
        end else if (ex >= 5'd20) begin
            n_xv5 = r_diff4[15] ? 16'h0000 : {1'b0, H_INF};
        end else if (!r_diff4[15] && (mag > 29'(12 << 24))) begin
            n_xv5 = {1'b0, H_INF};
        end else if (r_diff4[15] && (mag > 29'(18 << 24))) begin
            n_xv5 = 16'h0000;
        end else begin
            n_xs5 = 1'b0;
        end
    end

    assign a7 = r_p6[62:31] + {31'd0, r_p6[30]};
    assign b8 = r_p7[62:31] + {31'd0, r_p7[30]};

    // Stage 9 logic: normalize the product and round exp to fp16.
    always_comb begin
        logic [1:0]  lz;
        logic [63:0] norm;
        logic signed [9:0] e;
        lz   = r_p8[63] ? 2'd0 : (r_p8[62] ? 2'd1 : 2'd2);
        norm = r_p8 << lz;
        e    = 10'(r_e8) + 10'sd2 - $signed({8'd0, lz});
        n_ratio9 = r_xs8 ? r_xv8 : round_pack(1'b0, e, norm[63:24], |norm[23:0]);
    end

    // Stage 10 logic: significand product and special operands.
    always_comb begin
        logic [10:0] siga;
        logic [10:0] sigb;
        logic signed [6:0] ea;
        logic signed [6:0] eb;
        logic za;
        logic zb;
        siga = {r_val9[14:10] != 5'd0, r_val9[9:0]};
        sigb = {r_ratio9[14:10] != 5'd0, r_ratio9[9:0]};
        ea   = (r_val9[14:10] == 5'd0) ? -7'sd14 : $signed({2'b00, r_val9[14:10]}) - 7'sd15;
        eb   = (r_ratio9[14:10] == 5'd0) ? -7'sd14
                                         : $signed({2'b00, r_ratio9[14:10]}) - 7'sd15;
        za   = (r_val9[14:0] == 15'd0);
        zb   = (r_ratio9[14:0] == 15'd0);
        n_prod10 = siga * sigb;
        n_es10   = ea + eb;
        n_ms10   = r_val9[15] ^ r_ratio9[15];
        n_msp10  = 1'b1;
        if (is_nan(r_val9) || is_nan(r_ratio9) ||
            (is_inf(r_val9) && zb) || (is_inf(r_ratio9) && za)) begin
            n_mspv10 = H_QNAN;
        end else if (is_inf(r_val9) || is_inf(r_ratio9)) begin
            n_mspv10 = {n_ms10, H_INF};
        end else if (za || zb) begin
            n_mspv10 = {n_ms10, 15'd0};
        end else begin
            n_mspv10 = 16'h0000;
            n_msp10  = 1'b0;
        end
    end

    // Stage 12 logic: normalize and round the final product.
    always_comb begin
        logic [21:0] norm;
        logic signed [9:0] e;
        norm = r_prod11 << (5'd21 - r_lp11);
        e    = 10'(r_es11) + $signed({5'd0, r_lp11}) - 10'sd20;
        if (r_z[NS-2]) begin
            n_out = 16'h0000;
        end else if (r_msp11) begin
            n_out = r_mspv11;
        end else begin
            n_out = round_pack(r_ms11, e, {norm, 18'd0}, 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z <= {r_z[NS-2:0], i_ent.kind == KIND_ZERO};

            r_ga1  <= r_mem[AW'(i_ent.row)];
            r_gb1  <= r_mem[AW'(i_ent.col)];
            r_val1 <= i_ent.value;

            r_d2   <= n_d2;
            r_sp2  <= n_sp2;
            r_spv2 <= n_spv2;
            r_val2 <= r_val1;

            r_mag3 <= r_d2[42] ? 41'(-r_d2) : 41'(r_d2);
            r_p3   <= lead41(r_d2[42] ? 41'(-r_d2) : 41'(r_d2));
            r_nz3  <= (r_d2 != '0);
            r_s3   <= r_d2[42];
            r_sp3  <= r_sp2;
            r_spv3 <= r_spv2;
            r_val3 <= r_val2;

            r_diff4 <= n_diff4;
            r_val4  <= r_val3;

            r_x5   <= n_x5;
            r_xs5  <= n_xs5;
            r_xv5  <= n_xv5;
            r_val5 <= r_val4;

            r_p6   <= T_C2[r_x5[23:16]] * T_C1[r_x5[15:8]];
            r_c0_6 <= r_x5[7:0];
            r_c3_6 <= r_x5[29:24];
            r_xs6  <= r_xs5;
            r_xv6  <= r_xv5;
            r_val6 <= r_val5;

            r_p7   <= a7 * T_C0[r_c0_6];
            r_c3_7 <= r_c3_6;
            r_xs7  <= r_xs6;
            r_xv7  <= r_xv6;
            r_val7 <= r_val6;

            r_p8   <= b8 * T_C3M[r_c3_7];
            r_e8   <= $signed(T_C3E[r_c3_7]);
            r_xs8  <= r_xs7;
            r_xv8  <= r_xv7;
            r_val8 <= r_val7;

            r_ratio9 <= n_ratio9;
            r_val9   <= r_val8;

            r_prod10 <= n_prod10;
            r_es10   <= n_es10;
            r_ms10   <= n_ms10;
            r_msp10  <= n_msp10;
            r_mspv10 <= n_mspv10;

            r_prod11 <= r_prod10;
            r_lp11   <= lead22(r_prod10);
            r_es11   <= r_es10;
            r_ms11   <= r_ms10;
            r_msp11  <= r_msp10;
            r_mspv11 <= r_mspv10;

            r_out <= n_out;
        end
    end

endmodule

// File: src/causal_decay_mask_fp16.sv
// Top level of the fp16 causal decay mask block.
//
// Usage: items arrive on the i_valid / o_ready channel. An item with
// i_cmd = 0 writes i_half_value as the gate of row i_row_index and gives no
// result; a load whose index lies outside the tile is dropped. An item with
// i_cmd = 1 is a tile element and gives exactly one result on the
// o_valid / i_ready channel: value * exp(gate[row] - gate[col]) on or below
// the diagonal, and +0 above it or when an index lies outside the tile.
// Every operation rounds to nearest-even fp16.
// One item can be accepted every cycle while the queue is not full. Each
// element passes through the datapath pipeline: subtract, exp as a
// chain of three 32x32 table products, and the final multiply, each
// split across registered stages.
// A four-entry queue separates the input side from the datapath, so input
// keeps flowing while a result waits; when i_ready stays low the whole
// datapath holds and o_ready falls once the queue fills.
// Reset empties the queue and the pipeline. The gate memory is not cleared:
// every gate must be loaded before an element reads it.
module causal_decay_mask_fp16 #(
    parameter int SIDE = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_cmd,
    input  logic [cdm_pkg::IDX_W-1:0] i_row_index,
    input  logic [cdm_pkg::IDX_W-1:0] i_col_index,
    input  logic [15:0]               i_half_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [15:0]               o_masked_value
);
    import cdm_pkg::*;

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_qent push_ent;
    t_qent pop_ent;

    // Classify the incoming item and decide whether it enters the queue.
    cdm_front #(
        .SIDE (SIDE)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_half_value (i_half_value),
        .i_full       (full),
        .o_push       (push),
        .o_ent        (push_ent)
    );

    // Loads and elements stay in order, so an element always sees the gates
    // written by the loads that came before it.
    cdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (full),
        .o_valid (q_valid),
        .o_ent   (pop_ent),
        .i_pop   (pop)
    );

    cdm_back #(
        .SIDE (SIDE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ent_valid    (q_valid),
        .i_ent          (pop_ent),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_masked_value (o_masked_value)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the fp16 causal decay mask block.
`timescale 1ns / 1ps

module tb;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ELEM = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   RANDOM_ITEMS   = 1650;
    localparam int   HOLD_CYCLES    = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_cmd;
    logic [3:0]  i_row_index;
    logic [3:0]  i_col_index;
    logic [15:0] i_half_value;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_masked_value;

    causal_decay_mask_fp16 i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_half_value   (i_half_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_masked_value (o_masked_value)
    );

    // Our own copy of the gate memory, updated in acceptance order.
    logic [15:0] gate_copy [16];
    // Expected masked values, oldest first.
    logic [15:0] masked_due [$];

    int n_accepted;
    int n_errors;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    // One directed row. Where "known" is set the expected value is typed in;
    // otherwise it comes from the predictor.
    typedef struct {
        logic        cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        known;
        logic [15:0] want;
    } t_row;

    localparam int N_ROWS = 22;
    t_row directed [N_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic real half_to_real(input logic [15:0] h);
        real v;
        if (h[14:10] == 5'h1F) begin
            if (h[9:0] != 10'd0) begin
                return $bitstoreal(64'h7FF8_0000_0000_0000);
            end
            return $bitstoreal({h[15], 63'h7FF0_0000_0000_0000});
        end
        if (h[14:10] == 5'd0) begin
            v = real'(h[9:0]) * $pow(2.0, -24);
        end else begin
            v = real'({1'b1, h[9:0]}) * $pow(2.0, real'(int'(h[14:10]) - 25));
        end
        return h[15] ? -v : v;
    endfunction

    // Round a double to nearest-even fp16, with gradual underflow.
    function automatic logic [15:0] real_to_half(input real d);
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] halfway;
        logic [63:0] r;
        logic        s;
        int          ex;
        int          e;
        int          shift;
        b  = $realtobits(d);
        s  = b[63];
        ex = int'(b[62:52]);
        m  = {12'd0, b[51:0]};
        if (ex == 2047) begin
            return (m != 64'd0) ? 16'h7E00 : {s, 15'h7C00};
        end
        if (ex == 0) begin
            return {s, 15'd0};
        end
        e = ex - 1023;
        if (e > 15) begin
            return {s, 15'h7C00};
        end
        m     = m | (64'd1 << 52);
        shift = (e >= -14) ? 42 : 42 + (-14 - e);
        if (shift > 53) begin
            return {s, 15'd0};
        end
        q       = m >> shift;
        rem     = m & ((64'd1 << shift) - 64'd1);
        halfway = 64'd1 << (shift - 1);
        if (rem > halfway || (rem == halfway && q[0])) begin
            q = q + 64'd1;
        end
        if (e >= -14) begin
            r = (64'(e + 14) << 10) + q;
            if (r >= 64'h7C00) begin
                return {s, 15'h7C00};
            end
            return {s, r[14:0]};
        end
        return {s, q[14:0]};
    endfunction

    // exp of an fp16 value, rounded once to fp16.
    function automatic logic [15:0] exp_of_half(input logic [15:0] h);
        real d;
        if (h[14:10] == 5'h1F && h[9:0] != 10'd0) begin
            return 16'h7E00;
        end
        d = half_to_real(h);
        if (d > 12.0) begin
            return 16'h7C00;
        end
        if (d < -18.0) begin
            return 16'h0000;
        end
        return real_to_half($exp(d));
    endfunction

    function automatic logic [15:0] decayed_value(input logic [3:0] row, input logic [3:0] col,
                                                  input logic [15:0] value);
        logic [15:0] diff;
        logic [15:0] ratio;
        if (col > row) begin
            return 16'h0000;
        end
        diff  = real_to_half(half_to_real(gate_copy[row]) - half_to_real(gate_copy[col]));
        ratio = exp_of_half(diff);
        return real_to_half(half_to_real(value) * half_to_real(ratio));
    endfunction

    // Offer one item, hold it until accepted, then update the predictor.
    task automatic offer_item(input logic cmd, input logic [3:0] row, input logic [3:0] col,
                              input logic [15:0] value, input logic known,
                              input logic [15:0] want);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_cmd        = cmd;
        i_row_index  = row;
        i_col_index  = col;
        i_half_value = value;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        if (cmd == CMD_LOAD) begin
            gate_copy[row] = value;
        end else begin
            masked_due.push_back(known ? want : decayed_value(row, col, value));
        end
        n_accepted++;
        @(negedge i_clk);
    endtask

    // Random gate: mostly moderate magnitudes so exp lands in range,
    // sometimes any pattern at all, infinities and NaN included.
    function automatic logic [15:0] random_gate();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom);
        end
        return {1'($urandom), 5'($urandom_range(9, 17)), 10'($urandom)};
    endfunction

    // Directed rows. All gates start at +0, so on or below the diagonal the
    // value passes through unchanged until some gates are rewritten.
    initial begin
        directed[0]  = '{CMD_ELEM, 4'd0,  4'd0,  16'h3C00, 1'b1, 16'h3C00};
        directed[1]  = '{CMD_ELEM, 4'd0,  4'd15, 16'hFFFF, 1'b1, 16'h0000};
        directed[2]  = '{CMD_ELEM, 4'd15, 4'd15, 16'h7BFF, 1'b1, 16'h7BFF};
        directed[3]  = '{CMD_ELEM, 4'd15, 4'd0,  16'h8001, 1'b1, 16'h8001};
        directed[4]  = '{CMD_ELEM, 4'd5,  4'd3,  16'h7E00, 1'b1, 16'h7E00};
        directed[5]  = '{CMD_ELEM, 4'd7,  4'd7,  16'hFC00, 1'b1, 16'hFC00};
        // Gate 15 = 12 and gate 0 = -9: the difference overflows exp.
        directed[6]  = '{CMD_LOAD, 4'd15, 4'd0,  16'h4A00, 1'b0, 16'h0000};
        directed[7]  = '{CMD_LOAD, 4'd0,  4'd9,  16'hC880, 1'b0, 16'h0000};
        directed[8]  = '{CMD_ELEM, 4'd15, 4'd0,  16'h3C00, 1'b1, 16'h7C00};
        directed[9]  = '{CMD_ELEM, 4'd15, 4'd0,  16'h0000, 1'b1, 16'h7E00};
        directed[10] = '{CMD_ELEM, 4'd15, 4'd0,  16'h7BFF, 1'b0, 16'h0000};
        directed[11] = '{CMD_ELEM, 4'd3,  4'd0,  16'h0001, 1'b0, 16'h0000};
        // Infinite gates: inf - inf is NaN, exp(+inf) is inf, exp(-inf) is 0.
        directed[12] = '{CMD_LOAD, 4'd1,  4'd0,  16'h7C00, 1'b0, 16'h0000};
        directed[13] = '{CMD_LOAD, 4'd2,  4'd0,  16'h7C00, 1'b0, 16'h0000};
        directed[14] = '{CMD_ELEM, 4'd2,  4'd1,  16'h3C00, 1'b1, 16'h7E00};
        directed[15] = '{CMD_ELEM, 4'd1,  4'd0,  16'h3C00, 1'b1, 16'h7C00};
        directed[16] = '{CMD_LOAD, 4'd4,  4'd0,  16'hFC00, 1'b0, 16'h0000};
        directed[17] = '{CMD_ELEM, 4'd4,  4'd3,  16'hBC00, 1'b1, 16'h8000};
        // A small gate against a tiny value drives the product to underflow.
        directed[18] = '{CMD_LOAD, 4'd5,  4'd0,  16'hC900, 1'b0, 16'h0000};
        directed[19] = '{CMD_ELEM, 4'd5,  4'd3,  16'h0400, 1'b0, 16'h0000};
        // A NaN gate poisons every element that reads it.
        directed[20] = '{CMD_LOAD, 4'd6,  4'd0,  16'h7E01, 1'b0, 16'h0000};
        directed[21] = '{CMD_ELEM, 4'd6,  4'd0,  16'h3555, 1'b1, 16'h7E00};
    end

    // Sender: reset, load every gate, walk the table, then random items in
    // four phases of sender idling and receiver stalls.
    initial begin
        logic [3:0] row;
        logic [3:0] col;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_cmd              = CMD_LOAD;
        i_row_index        = 4'd0;
        i_col_index        = 4'd0;
        i_half_value       = 16'd0;
        n_accepted         = 0;
        n_errors           = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every gate is written before any element can read it.
        for (int g = 0; g < 16; g++) begin
            offer_item(CMD_LOAD, 4'(g), 4'($urandom), 16'h0000, 1'b0, 16'h0000);
        end
        for (int k = 0; k < N_ROWS; k++) begin
            offer_item(directed[k].cmd, directed[k].row, directed[k].col, directed[k].value,
                       directed[k].known, directed[k].want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            case (k * 4 / RANDOM_ITEMS)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase
            row = 4'($urandom);
            col = 4'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                offer_item(CMD_LOAD, row, col, random_gate(), 1'b0, 16'h0000);
            end else begin
                // Bias toward the lower triangle, where the arithmetic lives.
                if (col > row && $urandom_range(0, 3) != 0) begin
                    offer_item(CMD_ELEM, col, row, 16'($urandom), 1'b0, 16'h0000);
                end else begin
                    offer_item(CMD_ELEM, row, col, 16'($urandom), 1'b0, 16'h0000);
                end
            end
        end
        i_valid = 1'b0;

        wait (masked_due.size() == 0);
        repeat (30) @(posedge i_clk);
        if (n_errors == 0 && masked_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: random stalls per phase, plus one long hold-off early on so
    // the internal queue fills and the block drops o_ready.
    initial begin
        bit held;
        held    = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_accepted >= 300) begin
                held    = 1'b1;
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready = i_rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        logic [15:0] want;
        logic        moved;
        moved = i_rst_n && i_valid && o_ready;
        if (o_valid && i_ready) begin
            moved = 1'b1;
            if (masked_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("unexpected item: masked_value %h", o_masked_value);
                end
            end else begin
                want = masked_due.pop_front();
                if (o_masked_value !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("masked_value mismatch: expected %h, got %h",
                                 want, o_masked_value);
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
